>>> rtl/global_alignment_min_cost_assert.svh
// Assertion macros for the global alignment block.
`ifndef GLOBAL_ALIGNMENT_MIN_COST_ASSERT_SVH
`define GLOBAL_ALIGNMENT_MIN_COST_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is held.
`define GAMC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define GAMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GAMC_ASSERT(lbl, clk, rstn, prop, msg)
`define GAMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/gamc_pkg.sv
// Shared types, constants and cost functions of the global alignment block.
package gamc_pkg;

    localparam int SCORE_W         = 20;
    localparam int BASE_W          = 3;
    localparam int GAP_W           = 8;
    localparam int SUB_W           = 64;
    localparam int COST_W          = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int DEFAULT_MAX_LEN = 1024;

    localparam logic [GAP_W-1:0] GAP_RESET = 8'd7;
    localparam logic [SUB_W-1:0] SUB_RESET = 64'h0134_1053_1502_4320;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SUB = 1'b1;

    // input item kinds (carried in s_tuser)
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    // token travelling down the cell chain with one streamed base
    typedef struct packed {
        logic              valid;
        logic              upd;    // base updates the column
        logic              first;  // first column: rebuild border values
        logic              last;   // emit the score at the chain end
        logic              ovf;    // capacity exceeded somewhere
        logic [BASE_W-1:0] base;
    } tok_t;

    // data handed from one cell to the next
    typedef struct packed {
        tok_t               tok;
        logic [SCORE_W-1:0] up;    // new value of the row above
        logic [SCORE_W-1:0] diag;  // old value of the row above
        logic [SCORE_W-1:0] init;  // border value + gap for the first column
    } cell_bus_t;

    // first-sequence load strobes broadcast to the cells
    typedef struct packed {
        logic wr_en;
        logic clr;
    } load_ctl_t;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_W] ? {SCORE_W{1'b1}} : s[SCORE_W-1:0];
    endfunction

    // row = first-sequence base, col = streamed base; N (and codes above) cost 0
    function automatic logic [COST_W-1:0] sub_cost(input logic [BASE_W-1:0] a,
                                                   input logic [BASE_W-1:0] b,
                                                   input logic [SUB_W-1:0]  costs);
        logic [3:0] idx;
        idx = {a[1:0], b[1:0]};
        if (a[2] || b[2]) begin
            return '0;
        end
        return costs[{idx, 2'b00} +: COST_W];
    endfunction

endpackage

>>> rtl/gamc_cell.sv
// One alignment cell: holds a first-sequence base and its row of the score column.
module gamc_cell import gamc_pkg::*; #(
    parameter int MAX_LEN  = DEFAULT_MAX_LEN,
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [GAP_W-1:0] gap,
    input  logic [SUB_W-1:0] subc,
    input  load_ctl_t        load_ctl,
    input  logic [IDX_W-1:0] load_pos,
    input  logic [BASE_W-1:0] load_base,
    input  cell_bus_t        in_bus,
    output cell_bus_t        out_bus
);

    logic [BASE_W-1:0]  base_reg;
    logic               active_reg;
    logic [SCORE_W-1:0] score_reg;
    cell_bus_t          out_reg;
    cell_bus_t          out_next;

    logic               hit;
    logic               work;
    logic [SCORE_W-1:0] old_val;
    logic [SCORE_W-1:0] t_up;
    logic [SCORE_W-1:0] t_left;
    logic [SCORE_W-1:0] t_diag;
    logic [SCORE_W-1:0] best;

    always_comb begin
        hit     = load_ctl.wr_en && (load_pos == IDX_W'(CELL_IDX));
        work    = in_bus.tok.valid && in_bus.tok.upd && active_reg;
        old_val = in_bus.tok.first ? in_bus.init : score_reg;
        t_up    = sat_add(in_bus.up, SCORE_W'(gap));
        t_left  = sat_add(old_val, SCORE_W'(gap));
        t_diag  = sat_add(in_bus.diag,
                          SCORE_W'(sub_cost(base_reg, in_bus.tok.base, subc)));
        best    = t_up;
        if (t_left < best) begin
            best = t_left;
        end
        if (t_diag < best) begin
            best = t_diag;
        end

        out_next     = in_bus;
        if (active_reg) begin
            out_next.up   = work ? best : score_reg;
            out_next.diag = old_val;
            out_next.init = t_left;
        end
    end

    // first-sequence storage, written only while the chain is drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            if (load_ctl.clr) begin
                active_reg <= 1'b0;
            end
            if (hit) begin
                active_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            base_reg <= load_base;
        end
        if (advance && work) begin
            score_reg <= best;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (advance) begin
            out_reg <= out_next;
        end
    end

    assign out_bus = out_reg;

endmodule

>>> rtl/gamc_ctrl.sv
// Input control: sequence lengths, column count, row 0 of the column, chain injection.
module gamc_ctrl import gamc_pkg::*; #(
    parameter int MAX_LEN = DEFAULT_MAX_LEN,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_op,
    input  logic [BASE_W-1:0] s_base,
    input  logic              s_last,
    input  logic              advance,
    input  logic [GAP_W-1:0]  gap,
    output logic              s_tready,
    output load_ctl_t         load_ctl,
    output logic [IDX_W-1:0]  load_pos,
    output cell_bus_t         head_bus
);

    localparam int PEND_W = $clog2(MAX_LEN + 2);
    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(MAX_LEN + 1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LEN);

    logic [LEN_W-1:0]   first_len_reg, first_len_next;
    logic               first_done_reg, first_done_next;
    logic               ovf_first_reg, ovf_first_next;
    logic [LEN_W-1:0]   col_cnt_reg, col_cnt_next;
    logic               strm_ovf_reg, strm_ovf_next;
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [SCORE_W-1:0] row0_reg, row0_next;
    cell_bus_t          head_reg, head_next;

    logic               is_load;
    logic               load_acc;
    logic               strm_acc;
    logic [LEN_W-1:0]   base_len;
    logic               room;
    logic               col_full;
    logic               sovf;
    logic [SCORE_W-1:0] old0;
    logic [SCORE_W-1:0] t0;

    always_comb begin
        is_load  = (s_op == OP_LOAD);
        // a load waits until every streamed base has left the chain
        s_tready = advance && (!is_load || (pend_reg == '0));
        load_acc = s_tvalid && s_tready && is_load;
        strm_acc = s_tvalid && s_tready && !is_load;

        base_len = first_done_reg ? '0 : first_len_reg;
        room     = (base_len != LEN_MAX);
        col_full = (col_cnt_reg == LEN_MAX);
        sovf     = strm_ovf_reg || col_full;

        load_ctl.wr_en = load_acc && room;
        load_ctl.clr   = load_acc && first_done_reg;
        load_pos       = base_len[IDX_W-1:0];

        old0 = (col_cnt_reg == '0) ? '0 : row0_reg;
        t0   = sat_add(old0, SCORE_W'(gap));

        first_len_next  = first_len_reg;
        first_done_next = first_done_reg;
        ovf_first_next  = ovf_first_reg;
        col_cnt_next    = col_cnt_reg;
        strm_ovf_next   = strm_ovf_reg;
        row0_next       = row0_reg;
        pend_next       = pend_reg;

        head_next                = head_reg;
        head_next.tok.valid      = 1'b0;
        head_next.tok.upd        = !col_full;
        head_next.tok.first      = (col_cnt_reg == '0);
        head_next.tok.last       = s_last;
        head_next.tok.ovf        = (first_done_reg ? 1'b0 : ovf_first_reg) || sovf;
        head_next.tok.base       = s_base;
        head_next.up             = col_full ? row0_reg : t0;
        head_next.diag           = old0;
        head_next.init           = t0;

        if (advance && (pend_reg != '0)) begin
            pend_next = pend_reg - PEND_W'(1);
        end

        if (load_acc) begin
            col_cnt_next    = '0;
            strm_ovf_next   = 1'b0;
            first_len_next  = base_len + LEN_W'(room);
            ovf_first_next  = (first_done_reg ? 1'b0 : ovf_first_reg) || !room;
            first_done_next = s_last;
        end

        if (strm_acc) begin
            head_next.tok.valid = 1'b1;
            head_next.tok.ovf   = ovf_first_reg || sovf;
            pend_next           = PEND_MAX;
            if (!col_full) begin
                row0_next    = t0;
                col_cnt_next = col_cnt_reg + LEN_W'(1);
            end
            if (s_last) begin
                col_cnt_next  = '0;
                strm_ovf_next = 1'b0;
            end else begin
                strm_ovf_next = sovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            first_done_reg <= 1'b0;
            ovf_first_reg  <= 1'b0;
            col_cnt_reg    <= '0;
            strm_ovf_reg   <= 1'b0;
            pend_reg       <= '0;
            head_reg       <= '0;
        end else begin
            first_len_reg  <= first_len_next;
            first_done_reg <= first_done_next;
            ovf_first_reg  <= ovf_first_next;
            col_cnt_reg    <= col_cnt_next;
            strm_ovf_reg   <= strm_ovf_next;
            pend_reg       <= pend_next;
            if (advance) begin
                head_reg <= head_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row0_reg <= row0_next;
    end

    assign head_bus = head_reg;

endmodule

>>> rtl/global_alignment_min_cost.sv
// Top level of the minimum-cost global alignment block: config, cell chain, output.
//
// Input stream (s_*): s_tuser is the kind of transfer (0 load a first-sequence
// base, 1 stream a second-sequence base), s_tdata[2:0] the base (A G C T N),
// s_tlast closes the current sequence. First-sequence bases are stored one per
// cell. Each streamed base then travels down the chain of MAX_LEN cells as a
// token, one cell per cycle while the chain is not stalled, and every cell
// updates its row of the score column. Streamed bases are taken back to back,
// one per cycle while the chain is not stalled. A load waits until the chain is
// empty. A streamed base with tlast yields one result on m_*: m_tdata[19:0] the
// cost, m_tuser the overflow flag. m_tvalid rises once that base has crossed the
// head stage and every cell and has been taken into the output register.
// The result sits in an output register; while it is stalled the chain keeps
// moving until the next result reaches the chain end, and only then does the
// whole chain and the input wait.
// cfg_wr_en/cfg_index/cfg_wdata write gap_cost (index 0) and the substitution
// matrix (index 1); write only while no transfer is in flight.
// Reset (aresetn low, synchronous) empties the chain and both sequences and
// restores the default costs.
module global_alignment_min_cost import gamc_pkg::*; #(
    parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [2:0] base, rest zero
    input  logic                 s_tuser,   // [0] op
    input  logic                 s_tlast,   // last
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [19:0] score, rest zero
    output logic                 m_tuser,   // [0] overflow
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUB_W-1:0]     cfg_wdata
);

`include "global_alignment_min_cost_assert.svh"

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [GAP_W-1:0]   gap_reg;
    logic [SUB_W-1:0]   sub_reg;

    logic               m_tvalid_reg;
    logic [SCORE_W-1:0] m_score_reg;
    logic               m_ovf_reg;

    cell_bus_t          chain [MAX_LEN+1];
    load_ctl_t          load_ctl;
    logic [IDX_W-1:0]   load_pos;
    logic               advance;
    logic               end_emit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= GAP_RESET;
            sub_reg <= SUB_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAP: gap_reg <= cfg_wdata[GAP_W-1:0];
                REG_SUB: sub_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // chain moves unless a result reaches the end while the last one is stuck
    assign end_emit = chain[MAX_LEN].tok.valid && chain[MAX_LEN].tok.last;
    assign advance  = !(end_emit && m_tvalid_reg && !m_tready);

    gamc_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_base   (s_tdata[BASE_W-1:0]),
        .s_last   (s_tlast),
        .advance  (advance),
        .gap      (gap_reg),
        .s_tready (s_tready),
        .load_ctl (load_ctl),
        .load_pos (load_pos),
        .head_bus (chain[0])
    );

    // cell k holds first-sequence base k (row k+1 of the column)
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        gamc_cell #(
            .MAX_LEN  (MAX_LEN),
            .CELL_IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .gap       (gap_reg),
            .subc      (sub_reg),
            .load_ctl  (load_ctl),
            .load_pos  (load_pos),
            .load_base (s_tdata[BASE_W-1:0]),
            .in_bus    (chain[k]),
            .out_bus   (chain[k+1])
        );
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (end_emit && advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_emit && advance) begin
            m_score_reg <= chain[MAX_LEN].up;
            m_ovf_reg   <= chain[MAX_LEN].tok.ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24 - SCORE_W){1'b0}}, m_score_reg};
    assign m_tuser  = m_ovf_reg;

    `GAMC_ASSERT(a_no_accept_on_stall, aclk, aresetn, !advance |-> !(s_tvalid && s_tready), "input transfer while chain stalled")
    `GAMC_ASSERT(a_emit_lands, aclk, aresetn, (end_emit && advance) |=> m_tvalid, "finished score not presented")
    `GAMC_ASSERT(a_valid_from_chain, aclk, aresetn, $rose(m_tvalid) |-> $past(end_emit), "result without a closing token")

endmodule
